@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the epoch corrector queue (stefc_fifo). Empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked every edge outside reset
`define STEFC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("stefc assertion failed");
// antecedent sampled out of reset, consequent checked at the next clock
`define STEFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((rst_n) && (ante)) |=> (cons)) \
        else $error("stefc assertion failed");
`else
`define STEFC_ASSERT(lbl, clk, rst_n, prop)
`define STEFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/stefc_pkg.sv @@
// ----------------------------------------------------------------------------
// stefc_pkg
// Types, constants and helpers for the short time epoch corrector.
// ----------------------------------------------------------------------------
`default_nettype none

package stefc_pkg;

    localparam int PATHS       = 256;
    // path index is 8 bits, so no more than 256 slots are ever addressed
    localparam int DEPTH_SLOTS = (PATHS < 256) ? PATHS : 256;
    localparam int SLOT_W      = (DEPTH_SLOTS > 1) ? $clog2(DEPTH_SLOTS) : 1;

    localparam int EPOCH_W = 48;
    localparam int SHORT_W = 16;
    localparam int SKEW_W  = 16;
    localparam int IDX_W   = 8;
    localparam int CFG_W   = 1;

    localparam logic [SKEW_W-1:0]  SKEW_RESET = 16'd500;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX  = {EPOCH_W{1'b1}};

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CLS_NOW,
        CLS_PASS,
        CLS_CORR
    } t_cls;

    typedef enum logic [2:0] {
        OC_PASSED   = 3'd0,
        OC_NOW      = 3'd1,
        OC_REPEAT   = 3'd2,
        OC_SEEDED   = 3'd3,
        OC_LATE     = 3'd4,
        OC_AHEAD    = 3'd5,
        OC_EXTENDED = 3'd6
    } t_outcome;

    typedef enum logic [CFG_W-1:0] {
        CFG_ENABLE = 1'b0,
        CFG_SKEW   = 1'b1
    } t_cfg_idx;

    // classified record handed from front to back
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        t_cls               cls;
        logic [EPOCH_W-1:0] base;   // now time for CLS_NOW, coarse otherwise
        logic [EPOCH_W-1:0] lo;     // coarse - skew, floored at 0
        logic [EPOCH_W:0]   hi;     // coarse + skew, unsaturated
        logic [SHORT_W-1:0] short_ms;
    } t_item;

    typedef struct packed {
        logic [EPOCH_W-1:0] anchor;
        logic [SHORT_W-1:0] short_ms;
    } t_entry;

    // index modulo slot count by conditional subtraction
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [31:0] rem;
        rem = {{(32 - IDX_W){1'b0}}, idx};
        for (int k = IDX_W - 1; k >= 0; k--) begin
            if (rem >= (32'(DEPTH_SLOTS) << k)) begin
                rem = rem - (32'(DEPTH_SLOTS) << k);
            end
        end
        return rem[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/short_time_epoch_corrector.sv @@
// ----------------------------------------------------------------------------
// short_time_epoch_corrector
// Extends 16-bit wrapping short times against a per-path anchor epoch.
//
//   channel   direction  handshake                    beat
//   in        input      i_in_valid / o_in_stall      one record
//   out       output     o_out_valid / i_out_stall    epoch and outcome
//   cfg       input      i_cfg_valid / o_cfg_ready    register index and data
//
// One record per cycle sustained while the output is not stalled; the per-path
// table does one read and one write per cycle, with same-path forwarding so
// back-to-back hits on a path need no bubble. A record passes through the
// front register, the queue, the table stage and the result register. Reset
// is synchronous; the anchor table is marked empty by per-slot valid bits, so
// no clearing pass runs. A stalled output fills the four-deep queue before
// the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module short_time_epoch_corrector import stefc_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [IDX_W-1:0]    i_path_index,
    input  wire logic [EPOCH_W-1:0]  i_coarse_msec,
    input  wire logic [EPOCH_W-1:0]  i_now_msec,
    input  wire logic                i_spontaneous,
    input  wire logic                i_has_short,
    input  wire logic [SHORT_W-1:0]  i_short_msec,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [EPOCH_W-1:0]       o_epoch_out,
    output logic [2:0]               o_outcome,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_W-1:0]    i_cfg_index,
    input  wire logic [SKEW_W-1:0]   i_cfg_data
);

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    t_item front_item;
    t_item head_item;

    stefc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_path_index  (i_path_index),
        .i_coarse_msec (i_coarse_msec),
        .i_now_msec    (i_now_msec),
        .i_spontaneous (i_spontaneous),
        .i_has_short   (i_has_short),
        .i_short_msec  (i_short_msec),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (push),
        .o_item        (front_item),
        .i_q_full      (q_full)
    );

    stefc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_empty (q_empty)
    );

    stefc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_item),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_epoch_out (o_epoch_out),
        .o_outcome   (o_outcome)
    );

endmodule

`default_nettype wire

@@ sv/stefc_front.sv @@
// ----------------------------------------------------------------------------
// stefc_front
// Accepts records, holds the config registers and classifies each record.
// ----------------------------------------------------------------------------
`default_nettype none

module stefc_front import stefc_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [IDX_W-1:0]    i_path_index,
    input  wire logic [EPOCH_W-1:0]  i_coarse_msec,
    input  wire logic [EPOCH_W-1:0]  i_now_msec,
    input  wire logic                i_spontaneous,
    input  wire logic                i_has_short,
    input  wire logic [SHORT_W-1:0]  i_short_msec,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_W-1:0]    i_cfg_index,
    input  wire logic [SKEW_W-1:0]   i_cfg_data,
    output logic                     o_push,
    output t_item                    o_item,
    input  wire logic                i_q_full
);

    logic              r_enable;
    logic [SKEW_W-1:0] r_skew;
    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic              load;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_valid && i_q_full;
    assign o_push      = r_valid && !i_q_full;
    assign o_item      = r_item;
    assign load        = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_skew   <= SKEW_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_SKEW:   r_skew   <= i_cfg_data;
                default:    r_enable <= r_enable;
            endcase
        end
    end

    always_comb begin
        n_item          = '0;
        n_item.slot     = slot_of(i_path_index);
        n_item.short_ms = i_short_msec;
        n_item.base     = i_coarse_msec;
        n_item.hi       = {1'b0, i_coarse_msec} + {{(EPOCH_W + 1 - SKEW_W){1'b0}}, r_skew};
        if (i_coarse_msec > {{(EPOCH_W - SKEW_W){1'b0}}, r_skew}) begin
            n_item.lo = i_coarse_msec - {{(EPOCH_W - SKEW_W){1'b0}}, r_skew};
        end else begin
            n_item.lo = '0;
        end
        if (i_coarse_msec == '0) begin
            n_item.cls  = CLS_NOW;
            n_item.base = i_now_msec;
        end else if (r_enable && !i_spontaneous && i_has_short) begin
            n_item.cls = CLS_CORR;
        end else begin
            n_item.cls = CLS_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/stefc_fifo.sv @@
// ----------------------------------------------------------------------------
// stefc_fifo
// Short queue of classified records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stefc_fifo import stefc_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_item  i_item,
    output logic        o_full,
    input  wire logic   i_pop,
    output t_item       o_head,
    output logic        o_empty
);

    t_item             r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

    `STEFC_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full && !i_pop))
    `STEFC_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty))
    `STEFC_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)
    `STEFC_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= QCNT_W'(QDEPTH))

endmodule

`default_nettype wire

@@ sv/stefc_back.sv @@
// ----------------------------------------------------------------------------
// stefc_back
// Per-path table read-modify-write, pinning and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stefc_back import stefc_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_item               i_head,
    input  wire logic                i_q_empty,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [EPOCH_W-1:0]       o_epoch_out,
    output logic [2:0]               o_outcome
);

    t_entry                 r_mem [DEPTH_SLOTS];
    logic [DEPTH_SLOTS-1:0] r_seen;
    t_entry                 r_rd;
    logic                   r_rd_seen;
    logic                   r_fwd;
    t_entry                 r_fwd_entry;

    logic                   r_b_valid;
    t_item                  r_b;
    logic                   r_out_valid;
    logic [EPOCH_W-1:0]     r_epoch;
    t_outcome               r_outcome;

    logic                   b_fire;
    logic                   wr_en;
    t_entry                 cur;
    t_entry                 wr_entry;
    logic [SHORT_W-1:0]     diff;
    logic [EPOCH_W:0]       ext;
    logic [EPOCH_W-1:0]     res_epoch;
    t_outcome               res_outcome;

    assign b_fire      = r_b_valid && (!r_out_valid || !i_out_stall);
    assign o_pop       = !i_q_empty && (!r_b_valid || b_fire);
    assign wr_en       = b_fire && (r_b.cls == CLS_CORR);
    assign o_out_valid = r_out_valid;
    assign o_epoch_out = r_epoch;
    assign o_outcome   = r_outcome;

    // entry as seen by the record in the back stage
    always_comb begin
        if (r_fwd) begin
            cur = r_fwd_entry;
        end else if (r_rd_seen) begin
            cur = r_rd;
        end else begin
            cur = '0;
        end
    end

    assign diff = r_b.short_ms - cur.short_ms;
    assign ext  = {1'b0, cur.anchor} + {{(EPOCH_W + 1 - SHORT_W){1'b0}}, diff};

    always_comb begin
        res_epoch   = r_b.base;
        res_outcome = OC_PASSED;
        wr_entry    = cur;
        case (r_b.cls)
            CLS_NOW: begin
                res_outcome = OC_NOW;
            end
            CLS_CORR: begin
                if (r_b.short_ms == cur.short_ms) begin
                    res_outcome     = OC_REPEAT;
                    wr_entry.anchor = r_b.base;
                end else if (cur.anchor == '0) begin
                    res_outcome = OC_SEEDED;
                    wr_entry    = '{anchor: r_b.base, short_ms: r_b.short_ms};
                end else begin
                    if (ext < {1'b0, r_b.lo}) begin
                        res_outcome = OC_LATE;
                        res_epoch   = r_b.lo;
                    end else if (ext > r_b.hi) begin
                        res_outcome = OC_AHEAD;
                        res_epoch   = r_b.hi[EPOCH_W] ? EPOCH_MAX : r_b.hi[EPOCH_W-1:0];
                    end else begin
                        res_outcome = OC_EXTENDED;
                        res_epoch   = ext[EPOCH_W] ? EPOCH_MAX : ext[EPOCH_W-1:0];
                    end
                    wr_entry = '{anchor: res_epoch, short_ms: r_b.short_ms};
                end
            end
            default: begin
                res_outcome = OC_PASSED;
            end
        endcase
    end

    // table: registered read on pop, write when a correcting record leaves
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_b.slot] <= wr_entry;
        end
        if (o_pop) begin
            r_rd        <= r_mem[i_head.slot];
            r_fwd_entry <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_rd_seen <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (wr_en) begin
                r_seen[r_b.slot] <= 1'b1;
            end
            if (o_pop) begin
                r_rd_seen <= r_seen[i_head.slot];
                // same slot written this edge: the read returned stale data
                r_fwd     <= wr_en && (r_b.slot == i_head.slot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b <= i_head;
        end
        if (b_fire) begin
            r_epoch   <= res_epoch;
            r_outcome <= res_outcome;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the short time epoch corrector. A local model of
// the per-path anchor table predicts each record's epoch and outcome; results
// are compared in order. Directed records cover the special cases and skew
// extremes. Random traffic is mostly per-path running clocks with jitter and
// some noise, under random gaps and stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stefc_pkg::*;

    localparam int STUCK_LIMIT = 3000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        logic [IDX_W-1:0]   path;
        logic [EPOCH_W-1:0] coarse;
        logic [EPOCH_W-1:0] now;
        logic               spont;
        logic               has_short;
        logic [SHORT_W-1:0] short_ms;
    } t_rec;

    typedef struct {
        logic [EPOCH_W-1:0] epoch;
        t_outcome           outcome;
    } t_expect;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [IDX_W-1:0]   i_path_index;
    logic [EPOCH_W-1:0] i_coarse_msec;
    logic [EPOCH_W-1:0] i_now_msec;
    logic               i_spontaneous;
    logic               i_has_short;
    logic [SHORT_W-1:0] i_short_msec;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [EPOCH_W-1:0] o_epoch_out;
    logic [2:0]         o_outcome;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_index;
    logic [SKEW_W-1:0]  i_cfg_data;

    // local copy of the table and registers
    logic [EPOCH_W-1:0] anchor_tbl [PATHS];
    logic [SHORT_W-1:0] short_tbl [PATHS];
    logic               corr_en;
    logic [SKEW_W-1:0]  skew_ms;

    t_expect            epoch_q[$];
    int                 errors;
    int                 idle_on;
    int                 hold_len;
    int                 stuck_cycles;

    // random traffic: a running clock per path and a few hot paths
    logic [63:0]        track_time [256];
    logic [IDX_W-1:0]   hot_path [8];

    short_time_epoch_corrector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_path_index  (i_path_index),
        .i_coarse_msec (i_coarse_msec),
        .i_now_msec    (i_now_msec),
        .i_spontaneous (i_spontaneous),
        .i_has_short   (i_has_short),
        .i_short_msec  (i_short_msec),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_epoch_out   (o_epoch_out),
        .o_outcome     (o_outcome),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_expect predict_epoch(input t_rec r);
        t_expect            e;
        int                 slot;
        logic [SHORT_W-1:0] diff;
        logic [63:0]        coarse64;
        logic [63:0]        ext;
        logic [63:0]        hi;
        logic [63:0]        newanc;
        slot = int'(r.path) % PATHS;
        e.epoch = r.coarse;
        e.outcome = OC_PASSED;
        if (r.coarse == '0) begin
            e.epoch = r.now;
            e.outcome = OC_NOW;
        end else if (corr_en && !r.spont && r.has_short) begin
            if (r.short_ms == short_tbl[slot]) begin
                // repeat only re-anchors, even on an unseen slot
                anchor_tbl[slot] = r.coarse;
                e.outcome = OC_REPEAT;
            end else if (anchor_tbl[slot] == '0) begin
                anchor_tbl[slot] = r.coarse;
                short_tbl[slot] = r.short_ms;
                e.outcome = OC_SEEDED;
            end else begin
                diff = r.short_ms - short_tbl[slot];
                coarse64 = 64'(r.coarse);
                ext = 64'(anchor_tbl[slot]) + 64'(diff);
                hi = coarse64 + 64'(skew_ms);
                if (ext + 64'(skew_ms) < coarse64) begin
                    newanc = (coarse64 > 64'(skew_ms)) ? coarse64 - 64'(skew_ms) : '0;
                    e.outcome = OC_LATE;
                end else if (ext > hi) begin
                    newanc = hi;
                    e.outcome = OC_AHEAD;
                end else begin
                    newanc = ext;
                    e.outcome = OC_EXTENDED;
                end
                if (newanc > 64'(EPOCH_MAX)) begin
                    newanc = 64'(EPOCH_MAX);
                end
                anchor_tbl[slot] = newanc[EPOCH_W-1:0];
                short_tbl[slot] = r.short_ms;
                e.epoch = newanc[EPOCH_W-1:0];
            end
        end
        return e;
    endfunction

    // predict on every accepted input beat
    always @(posedge i_clk) begin
        t_rec r;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            r.path = i_path_index;
            r.coarse = i_coarse_msec;
            r.now = i_now_msec;
            r.spont = i_spontaneous;
            r.has_short = i_has_short;
            r.short_ms = i_short_msec;
            epoch_q.insert(epoch_q.size(), predict_epoch(r));
        end
    end

    // compare every accepted output beat with the oldest prediction
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (epoch_q.size() == 0) begin
                $error("unexpected result: epoch_out %0d outcome %0d", o_epoch_out, o_outcome);
                errors++;
            end else begin
                e = epoch_q.pop_front();
                if (o_epoch_out !== e.epoch) begin
                    $error("epoch_out: expected %0d, got %0d", e.epoch, o_epoch_out);
                    errors++;
                end
                if (o_outcome !== e.outcome) begin
                    $error("outcome: expected %0d, got %0d", e.outcome, o_outcome);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // output side: random stall per result, or one long hold-off on request
    initial begin
        int stall_len;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                stall_len = hold_len;
            end else begin
                stall_len = idle_on ? int'($urandom_range(0, 15)) : 0;
            end
            hold_len = 0;
            if (stall_len > 0) begin
                i_out_stall = 1'b1;
                repeat (stall_len) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // returns at the edge where the beat is taken; valid stays high
    task automatic send_record(input t_rec r);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 15)) : 0;
        @(negedge i_clk);
        repeat (gap) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_path_index = r.path;
        i_coarse_msec = r.coarse;
        i_now_msec = r.now;
        i_spontaneous = r.spont;
        i_has_short = r.has_short;
        i_short_msec = r.short_ms;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_fields(input logic [IDX_W-1:0] path, input logic [EPOCH_W-1:0] coarse,
                               input logic [EPOCH_W-1:0] now, input logic spont,
                               input logic has_short, input logic [SHORT_W-1:0] short_ms);
        t_rec r;
        r.path = path;
        r.coarse = coarse;
        r.now = now;
        r.spont = spont;
        r.has_short = has_short;
        r.short_ms = short_ms;
        send_record(r);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (epoch_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [SKEW_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ENABLE: corr_en = val[0];
            CFG_SKEW:   skew_ms = val;
            default:    ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [EPOCH_W-1:0] rand_epoch();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[EPOCH_W-1:0];
    endfunction

    function automatic t_rec make_record(input int span);
        t_rec        r;
        logic [63:0] c;
        int          p;
        int          off;
        if ($urandom_range(0, 9) < 7) begin
            p = int'(hot_path[$urandom_range(0, 7)]);
        end else begin
            p = int'($urandom_range(0, 255));
        end
        r.path = p[IDX_W-1:0];
        r.now = rand_epoch();
        if ($urandom_range(0, 99) < 75) begin
            // well-formed: path clock advances, short time follows it
            if ($urandom_range(0, 3) == 0) begin
                track_time[p] = track_time[p] + 64'($urandom_range(0, 70000));
            end else begin
                track_time[p] = track_time[p] + 64'($urandom_range(0, 300));
            end
            if (track_time[p] > 64'(EPOCH_MAX)) begin
                track_time[p] = 64'(EPOCH_MAX);
            end
            off = int'($urandom_range(0, span));
            if ($urandom_range(0, 1) == 1 && track_time[p] > 64'(off)) begin
                c = track_time[p] - 64'(off);
            end else begin
                c = track_time[p] + 64'(off);
            end
            if (c > 64'(EPOCH_MAX)) begin
                c = 64'(EPOCH_MAX);
            end
            if (c == '0) begin
                c = 64'd1;
            end
            r.coarse = c[EPOCH_W-1:0];
            r.short_ms = track_time[p][SHORT_W-1:0];
            r.spont = 1'b0;
            r.has_short = 1'b1;
        end else begin
            r.coarse = ($urandom_range(0, 9) == 0) ? '0 : rand_epoch();
            r.spont = 1'($urandom_range(0, 1));
            r.has_short = 1'($urandom_range(0, 1));
            r.short_ms = 16'($urandom_range(0, 65535));
        end
        return r;
    endfunction

    task automatic test_reset_defaults;
        // correction is off after reset
        send_fields(8'd0, '0, EPOCH_MAX, 1'b0, 1'b1, 16'hFFFF);
        send_fields(8'd255, EPOCH_MAX, '0, 1'b0, 1'b1, 16'h1234);
        send_fields(8'd7, '0, '0, 1'b1, 1'b0, 16'h0000);
        drain();
    endtask

    task automatic test_correction_cases;
        write_reg(CFG_ENABLE, 16'd1);
        send_fields(8'd0, 48'd1000, 48'd1, 1'b0, 1'b1, 16'd0);     // repeat on unseen slot
        send_fields(8'd1, 48'd5000, 48'd1, 1'b0, 1'b1, 16'd5);     // seeded
        send_fields(8'd1, 48'd5015, 48'd1, 1'b0, 1'b1, 16'd20);    // extended
        send_fields(8'd1, 48'd7000, 48'd1, 1'b0, 1'b1, 16'd20);    // repeat
        send_fields(8'd1, 48'd7000, 48'd1, 1'b0, 1'b1, 16'd10);    // wraps, pinned ahead
        send_fields(8'd1, 48'd20000, 48'd1, 1'b0, 1'b1, 16'd11);   // pinned late
        send_fields(8'd1, 48'd20000, 48'd1, 1'b1, 1'b1, 16'd12);   // spontaneous
        send_fields(8'd1, 48'd20000, 48'd1, 1'b0, 1'b0, 16'd13);   // no short time
        send_fields(8'd1, '0, 48'd777, 1'b0, 1'b1, 16'd14);        // now used
        drain();
    endtask

    task automatic test_skew_extremes;
        write_reg(CFG_SKEW, 16'd0);
        send_fields(8'd3, 48'd1000, '0, 1'b0, 1'b1, 16'd1);
        send_fields(8'd3, 48'd1001, '0, 1'b0, 1'b1, 16'd2);
        send_fields(8'd3, 48'd1001, '0, 1'b0, 1'b1, 16'd3);
        drain();
        write_reg(CFG_SKEW, 16'hFFFF);
        send_fields(8'd4, 48'd10, '0, 1'b0, 1'b1, 16'd1);
        send_fields(8'd4, 48'd70000, '0, 1'b0, 1'b1, 16'd2);
        // extension saturates at the top of the epoch range
        send_fields(8'd5, EPOCH_MAX - 48'd10, '0, 1'b0, 1'b1, 16'd1);
        send_fields(8'd5, EPOCH_MAX, '0, 1'b0, 1'b1, 16'd100);
        drain();
        write_reg(CFG_SKEW, 16'd10);
        send_fields(8'd6, EPOCH_MAX - 48'd5, '0, 1'b0, 1'b1, 16'd1);
        send_fields(8'd6, EPOCH_MAX - 48'd1, '0, 1'b0, 1'b1, 16'd50);
        drain();
    endtask

    task automatic test_random_traffic(input int count, input int span);
        for (int i = 0; i < count; i++) begin
            send_record(make_record(span));
        end
        drain();
    endtask

    task automatic test_output_holdoff;
        t_rec r;
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_SKEW, 16'd500);
        idle_on = 0;
        hold_len = 300;
        for (int i = 0; i < 40; i++) begin
            r = make_record(1000);
            send_record(r);
        end
        drain();
        idle_on = 1;
    endtask

    initial begin
        int skew;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_path_index = '0;
        i_coarse_msec = '0;
        i_now_msec = '0;
        i_spontaneous = 1'b0;
        i_has_short = 1'b0;
        i_short_msec = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        idle_on = 1;
        hold_len = 0;
        stuck_cycles = 0;
        corr_en = 1'b0;
        skew_ms = SKEW_RESET;
        for (int k = 0; k < PATHS; k++) begin
            anchor_tbl[k] = '0;
            short_tbl[k] = '0;
        end
        for (int k = 0; k < 256; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                track_time[k] = 64'(EPOCH_MAX) - 64'($urandom_range(0, 2000000));
            end else begin
                track_time[k] = {16'd0, 16'($urandom_range(0, 65535)), $urandom};
            end
        end
        for (int k = 0; k < 8; k++) begin
            hot_path[k] = 8'($urandom_range(0, 255));
        end

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_correction_cases();
        test_skew_extremes();

        skew = int'($urandom_range(1, 2000));
        write_reg(CFG_SKEW, skew[SKEW_W-1:0]);
        test_random_traffic(250, 2 * skew + 50);

        idle_on = 0;
        write_reg(CFG_SKEW, 16'd0);
        test_random_traffic(150, 20);
        idle_on = 1;

        write_reg(CFG_SKEW, 16'hFFFF);
        test_random_traffic(150, 100000);

        write_reg(CFG_ENABLE, 16'd0);
        test_random_traffic(80, 1000);

        test_output_holdoff();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
